>>> rtl/assert_macros.svh
// Assertion macros for the checker in bcde_chk.sv.
// Every macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bcde_pkg.sv
`timescale 1ns / 1ps

package bcde_pkg;

	localparam int PIX_W    = 8;
	localparam int SUM_W    = 10;
	localparam int ROW_W    = 16;
	localparam int IMG_W_W  = 11;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic MODE_DILATE = 1'b0;
	localparam logic MODE_ERODE  = 1'b1;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd128;
	localparam logic [ROW_W-1:0]   HEIGHT_RST = 16'd128;

	localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;
	localparam logic [SUM_W-1:0] SUM_FULL4 = SUM_W'(4 * 255);
	localparam logic [SUM_W-1:0] SUM_FULL3 = SUM_W'(3 * 255);
	localparam logic [SUM_W-1:0] SUM_FULL2 = SUM_W'(2 * 255);

	// One line buffer entry: the pixel of the row before and of the latest row.
	typedef struct packed {
		logic [PIX_W-1:0] older;
		logic [PIX_W-1:0] newer;
	} line_t;

	typedef struct packed {
		logic             mode;
		logic             restart;
		logic [ROW_W-1:0] hlast;
	} cfg_t;

	typedef struct packed {
		logic             mode;
		logic             edge_r;
		logic             edge_c;
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] right;
		logic [PIX_W-1:0] down;
	} nbr_t;

endpackage

>>> rtl/bcde_ram.sv
`timescale 1ns / 1ps

module bcde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

>>> rtl/bcde_cfg.sv
`timescale 1ns / 1ps

module bcde_cfg #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bcde_pkg::PADDR_W-1:0]  paddr,
	input  logic [bcde_pkg::PDATA_W-1:0]  pwdata,
	output logic [bcde_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output bcde_pkg::cfg_t                cfg,
	output logic [$clog2(MAX_WIDTH)-1:0]  wlast
);

	import bcde_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic               wr;
	logic [1:0]         idx;
	logic               mode_q;
	logic [IMG_W_W-1:0] width_q;
	logic [ROW_W-1:0]   height_q;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DILATE;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr) begin
			case (idx)
				REG_MODE:   mode_q   <= pwdata[0];
				REG_WIDTH:  width_q  <= pwdata[IMG_W_W-1:0];
				REG_HEIGHT: height_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:   prdata = {{(PDATA_W-1){1'b0}}, mode_q};
			REG_WIDTH:  prdata = {{(PDATA_W-IMG_W_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(PDATA_W-ROW_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	// A width beyond the line buffer uses the whole buffer; zero counts as one.
	always_comb begin
		if (32'(width_q) > 32'(MAX_WIDTH)) begin
			wlast = CW'(MAX_WIDTH - 1);
		end else if (width_q == '0) begin
			wlast = '0;
		end else begin
			wlast = CW'(width_q - 11'd1);
		end
	end

	always_comb begin
		cfg.mode    = mode_q;
		cfg.restart = wr && (idx inside {REG_WIDTH, REG_HEIGHT});
		cfg.hlast   = (height_q == '0) ? '0 : height_q - 16'd1;
	end

endmodule

>>> rtl/bcde_decide.sv
`timescale 1ns / 1ps

module bcde_decide (
	input  bcde_pkg::nbr_t nb,
	output logic           set
);

	import bcde_pkg::*;

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] target;

	assign sum = SUM_W'(nb.up) + SUM_W'(nb.left) + SUM_W'(nb.right) + SUM_W'(nb.down);

	// Erosion needs every neighbor inside the image to be full white.
	always_comb begin
		case ({nb.edge_r, nb.edge_c})
			2'b00:   target = SUM_FULL4;
			2'b11:   target = SUM_FULL2;
			default: target = SUM_FULL3;
		endcase
	end

	assign set = (nb.mode == MODE_DILATE) ? (sum >= SUM_W'(PIX_MAX)) : (sum == target);

endmodule

>>> rtl/binary_cross_dilate_erode.sv
`timescale 1ns / 1ps
// Channel   Handshake                    Payload
// item      item_valid / item_stall      cmd, pixel
// result    result_valid / result_stall  pixel_set, frame_last
// config    APB write/read               mode, image_width, image_height
//
// One item is taken per cycle while item_stall is low; a result is registered and shows in the cycle after its item.
// Results of a row leave while the next row comes in; the last row leaves on drain ticks.
// Both line buffers share one RAM with two registered read ports, read one column ahead.
// Reset clears positions and the result valid flag; the result payload and line buffers are not cleared.
// The item side stalls only while a result waits and the result side stalls.

module binary_cross_dilate_erode #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          cmd,
	input  logic [bcde_pkg::PIX_W-1:0]    pixel,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          pixel_set,
	output logic                          frame_last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bcde_pkg::PADDR_W-1:0]  paddr,
	input  logic [bcde_pkg::PDATA_W-1:0]  pwdata,
	output logic [bcde_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	import bcde_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	cfg_t             cfg;
	logic [CW-1:0]    wlast;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             drain_q;
	logic [PIX_W-1:0] left_q;

	logic [CW-1:0]    n_col;
	logic [ROW_W-1:0] n_row;
	logic             n_drain;
	logic [CW-1:0]    rd_addr1;

	line_t            rd0;
	line_t            rd1;
	line_t            wdata;
	line_t            byp_q;
	logic             hit0_q;
	logic             hit1_q;
	line_t            w0;
	logic [PIX_W-1:0] w1_newer;

	logic             accept;
	logic             pix_step;
	logic             drn_step;
	logic             step;
	logic             emit;
	logic             col_first;
	logic             col_last;
	logic             row_last;
	nbr_t             nb;
	logic             dec_set;

	logic             result_valid_q;
	logic             pixel_set_q;
	logic             frame_last_q;

	bcde_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.wlast   (wlast)
	);

	assign item_stall = result_valid_q & result_stall;
	assign accept     = item_valid & ~item_stall;
	assign pix_step   = accept & ~drain_q & (cmd == CMD_PIXEL);
	assign drn_step   = accept & drain_q & (cmd == CMD_DRAIN);
	assign step       = pix_step | drn_step;
	assign emit       = (pix_step & (row_q != '0)) | drn_step;

	assign col_first = (col_q == '0);
	assign col_last  = (col_q == wlast);
	assign row_last  = (row_q == cfg.hlast);

	// A transfer written to a column the next read also fetches is forwarded here.
	assign w0       = hit0_q ? byp_q : rd0;
	assign w1_newer = hit1_q ? byp_q.newer : rd1.newer;

	always_comb begin
		n_col   = col_q;
		n_row   = row_q;
		n_drain = drain_q;
		if (cfg.restart) begin
			n_col   = '0;
			n_row   = '0;
			n_drain = 1'b0;
		end else if (step) begin
			if (col_last) begin
				n_col = '0;
				if (drain_q) begin
					n_row   = '0;
					n_drain = 1'b0;
				end else if (row_last) begin
					n_drain = 1'b1;
				end else begin
					n_row = row_q + 16'd1;
				end
			end else begin
				n_col = col_q + CW'(1);
			end
		end
	end

	assign rd_addr1    = n_col + CW'(1);
	assign wdata.older = w0.newer;
	assign wdata.newer = pixel;

	bcde_ram #(.WIDTH($bits(line_t)), .DEPTH(MAX_WIDTH)) u_ram (
		.clk    (clk),
		.we     (pix_step),
		.waddr  (col_q),
		.wdata  (wdata),
		.raddr0 (n_col),
		.raddr1 (rd_addr1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= 1'b0;
			left_q  <= '0;
			hit0_q  <= 1'b0;
			hit1_q  <= 1'b0;
		end else begin
			col_q   <= n_col;
			row_q   <= n_row;
			drain_q <= n_drain;
			hit0_q  <= pix_step && (col_q == n_col);
			hit1_q  <= pix_step && (col_q == rd_addr1);
			if (cfg.restart) begin
				left_q <= '0;
			end else if (step) begin
				left_q <= w0.newer;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_step) begin
			byp_q <= wdata;
		end
	end

	// In the drain phase the row below is outside the image.
	always_comb begin
		nb.mode   = cfg.mode;
		nb.edge_r = drain_q | (row_q == 16'd1);
		nb.edge_c = col_first | col_last;
		if (drain_q) begin
			nb.up   = (cfg.hlast != '0) ? w0.older : '0;
			nb.down = '0;
		end else begin
			nb.up   = (row_q[ROW_W-1:1] != '0) ? w0.older : '0;
			nb.down = pixel;
		end
		nb.left  = col_first ? '0 : left_q;
		nb.right = col_last ? '0 : w1_newer;
	end

	bcde_decide u_decide (
		.nb  (nb),
		.set (dec_set)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_set_q  <= dec_set;
			frame_last_q <= drn_step & col_last;
		end
	end

	assign result_valid = result_valid_q;
	assign pixel_set    = pixel_set_q;
	assign frame_last   = frame_last_q;

endmodule

>>> rtl/bcde_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcde_chk (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input logic result_valid,
	input logic result_stall,
	input logic pixel_set,
	input logic frame_last
);

	logic blocked;
	logic taken;

	assign blocked = result_valid && result_stall;
	assign taken   = item_valid && !item_stall;

	`ASSERT_NEXT(a_res_hold, blocked, result_valid, "result dropped while stalled")
	`ASSERT_NEXT(a_res_stable, blocked, $stable({pixel_set, frame_last}), "stalled result changed")
	`ASSERT_NOW(a_stall_full, blocked, item_stall, "item taken while result register blocked")
	`ASSERT_NOW(a_stall_cause, item_stall, blocked, "item stalled without a blocked result")
	`ASSERT_NOW(a_res_source, $rose(result_valid), $past(taken), "result without an item transfer")

endmodule

bind binary_cross_dilate_erode bcde_chk u_bcde_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.pixel_set    (pixel_set),
	.frame_last   (frame_last)
);
